// ===== src/upds_pkg.sv =====
// ----------------------------------------------------------------------------
// upds_pkg
// Shared types and constants for the url percent-decode and splitter block.
// ----------------------------------------------------------------------------
package upds_pkg;

   // characters the parser looks for
   localparam logic [7:0] CharPercent = 8'h25;
   localparam logic [7:0] CharColon   = 8'h3A;
   localparam logic [7:0] CharSlash   = 8'h2F;
   localparam logic [7:0] CharQuest   = 8'h3F;

   // section codes
   localparam logic [2:0] SecProto = 3'd0;
   localparam logic [2:0] SecHost  = 3'd1;
   localparam logic [2:0] SecPort  = 3'd2;
   localparam logic [2:0] SecPath  = 3'd3;
   localparam logic [2:0] SecQuery = 3'd4;

   // status codes
   localparam logic [2:0] StatOk         = 3'd0;
   localparam logic [2:0] StatBadHex     = 3'd1;
   localparam logic [2:0] StatIncomplete = 3'd2;
   localparam logic [2:0] StatNoSep      = 3'd3;
   localparam logic [2:0] StatEmptyProto = 3'd4;
   localparam logic [2:0] StatEmptyPort  = 3'd5;
   localparam logic [2:0] StatEmptyHost  = 3'd6;

   // byte results one input byte can cause at most
   localparam int SlotCount  = 3;
   localparam int SlotWidth  = $clog2(SlotCount + 1);
   localparam int QueueDepth = 4;
   localparam int QueuePtrW  = $clog2(QueueDepth);
   localparam int QueueCntW  = $clog2(QueueDepth + 1);

   typedef enum logic [1:0] {
      ESC_NONE,
      ESC_HIGH,
      ESC_LOW
   } escape_type;

   // work for the back end produced by one input byte
   typedef struct packed {
      logic [SlotCount-1:0][7:0] slot_byte;
      logic [SlotCount-1:0][2:0] slot_sec;
      logic [SlotWidth-1:0]      count;
      logic                      last;
      logic [2:0]                status;
   } packet_type;

endpackage

// ===== src/upds_front.sv =====
// ----------------------------------------------------------------------------
// upds_front
// Accepts raw bytes, percent-decodes them and splits them into sections.
// ----------------------------------------------------------------------------
module upds_front import upds_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  logic [7:0] req_in_byte,
   input  logic       req_last_byte,
   input  logic       q_full,
   output logic       pkt_push,
   output packet_type pkt
);

   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [4:0] r;
      r = '0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, c[3:0]};
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         r = {1'b1, c[3:0] + 4'd9};
      end
      return r;
   endfunction

   escape_type           esc_ff, esc_in;
   logic [3:0]           hi_ff, hi_in;
   logic [2:0]           sec_ff, sec_in;
   logic [1:0]           match_ff, match_in;
   logic [2:0]           flags_ff, flags_in;
   logic                 port_ff, port_in;
   logic [1:0]           err_ff, err_in;

   logic                 accept;
   logic                 dec_valid;
   logic [7:0]           dec_byte;
   logic [4:0]           hex;
   logic                 do_fresh;
   logic [SlotWidth-1:0] n;
   logic [2:0]           st;

   assign accept = req_push && !q_full;

   always_comb begin
      esc_in    = esc_ff;
      hi_in     = hi_ff;
      sec_in    = sec_ff;
      match_in  = match_ff;
      flags_in  = flags_ff;
      port_in   = port_ff;
      err_in    = err_ff;
      dec_valid = 1'b0;
      dec_byte  = req_in_byte;
      hex       = hex_decode(req_in_byte);
      do_fresh  = 1'b0;
      n         = '0;
      st        = StatOk;
      pkt       = '0;

      // percent decoding
      if (err_ff == 2'd0) begin
         if (esc_ff == ESC_NONE) begin
            if (req_in_byte == CharPercent) begin
               esc_in = ESC_HIGH;
            end else begin
               dec_valid = 1'b1;
            end
         end else if (!hex[4]) begin
            err_in = StatBadHex[1:0];
            esc_in = ESC_NONE;
         end else if (esc_ff == ESC_HIGH) begin
            hi_in  = hex[3:0];
            esc_in = ESC_LOW;
         end else begin
            esc_in    = ESC_NONE;
            dec_valid = 1'b1;
            dec_byte  = {hi_ff, hex[3:0]};
         end
      end

      // section split
      if (dec_valid) begin
         unique case (sec_ff)
            SecProto: begin
               if (match_ff == 2'd0) begin
                  do_fresh = 1'b1;
               end else if (match_ff == 2'd1) begin
                  if (dec_byte == CharSlash) begin
                     match_in = 2'd2;
                  end else begin
                     match_in = 2'd0;
                     pkt.slot_byte[n] = CharColon;
                     pkt.slot_sec[n]  = SecProto;
                     n = n + 1'b1;
                     flags_in[0] = 1'b1;
                     do_fresh = 1'b1;
                  end
               end else begin
                  match_in = 2'd0;
                  if (dec_byte == CharSlash) begin
                     sec_in = SecHost;
                  end else begin
                     pkt.slot_byte[n] = CharColon;
                     pkt.slot_sec[n]  = SecProto;
                     n = n + 1'b1;
                     pkt.slot_byte[n] = CharSlash;
                     pkt.slot_sec[n]  = SecProto;
                     n = n + 1'b1;
                     flags_in[0] = 1'b1;
                     do_fresh = 1'b1;
                  end
               end
            end
            SecHost: begin
               if (dec_byte == CharColon) begin
                  sec_in  = SecPort;
                  port_in = 1'b1;
               end else if (dec_byte == CharSlash) begin
                  sec_in = SecPath;
               end else begin
                  pkt.slot_byte[n] = dec_byte;
                  pkt.slot_sec[n]  = SecHost;
                  n = n + 1'b1;
                  flags_in[1] = 1'b1;
               end
            end
            SecPort: begin
               if (dec_byte == CharSlash) begin
                  sec_in = SecPath;
               end else begin
                  pkt.slot_byte[n] = dec_byte;
                  pkt.slot_sec[n]  = SecPort;
                  n = n + 1'b1;
                  flags_in[2] = 1'b1;
               end
            end
            SecPath: begin
               if (dec_byte == CharQuest) begin
                  sec_in = SecQuery;
               end else begin
                  pkt.slot_byte[n] = dec_byte;
                  pkt.slot_sec[n]  = SecPath;
                  n = n + 1'b1;
               end
            end
            default: begin
               pkt.slot_byte[n] = dec_byte;
               pkt.slot_sec[n]  = SecQuery;
               n = n + 1'b1;
            end
         endcase
      end

      // fresh protocol byte
      if (do_fresh) begin
         if (dec_byte == CharColon) begin
            match_in = 2'd1;
         end else begin
            pkt.slot_byte[n] = dec_byte;
            pkt.slot_sec[n]  = SecProto;
            n = n + 1'b1;
            flags_in[0] = 1'b1;
         end
      end

      // end of url
      if (req_last_byte) begin
         if (err_in == 2'd0 && esc_in != ESC_NONE) begin
            err_in = StatIncomplete[1:0];
         end
         if (err_in != 2'd0) begin
            st = {1'b0, err_in};
         end else if (sec_in == SecProto) begin
            if (match_in >= 2'd1) begin
               pkt.slot_byte[n] = CharColon;
               pkt.slot_sec[n]  = SecProto;
               n = n + 1'b1;
            end
            if (match_in >= 2'd2) begin
               pkt.slot_byte[n] = CharSlash;
               pkt.slot_sec[n]  = SecProto;
               n = n + 1'b1;
            end
            st = StatNoSep;
         end else if (!flags_in[0]) begin
            st = StatEmptyProto;
         end else if (port_in && !flags_in[2]) begin
            st = StatEmptyPort;
         end else if (!flags_in[1]) begin
            st = StatEmptyHost;
         end else begin
            st = StatOk;
         end
         esc_in   = ESC_NONE;
         hi_in    = '0;
         sec_in   = SecProto;
         match_in = '0;
         flags_in = '0;
         port_in  = 1'b0;
         err_in   = '0;
      end

      pkt.count  = n;
      pkt.last   = req_last_byte;
      pkt.status = st;
   end

   assign pkt_push = accept && (n != '0 || req_last_byte);

   always_ff @(posedge clock) begin
      if (reset) begin
         esc_ff   <= ESC_NONE;
         hi_ff    <= '0;
         sec_ff   <= SecProto;
         match_ff <= '0;
         flags_ff <= '0;
         port_ff  <= 1'b0;
         err_ff   <= '0;
      end else if (accept) begin
         esc_ff   <= esc_in;
         hi_ff    <= hi_in;
         sec_ff   <= sec_in;
         match_ff <= match_in;
         flags_ff <= flags_in;
         port_ff  <= port_in;
         err_ff   <= err_in;
      end
   end

endmodule

// ===== src/upds_queue.sv =====
// ----------------------------------------------------------------------------
// upds_queue
// Short packet queue between the front end and the back end.
// ----------------------------------------------------------------------------
module upds_queue import upds_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  packet_type push_data,
   output logic       full,
   input  logic       pop,
   output packet_type pop_data,
   output logic       empty
);

   packet_type           mem_ff [QueueDepth];
   logic [QueuePtrW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QueueCntW-1:0] cnt_ff;
   logic                 do_push, do_pop;

   assign full     = (cnt_ff == QueueCntW'(QueueDepth));
   assign empty    = (cnt_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

endmodule

// ===== src/upds_back.sv =====
// ----------------------------------------------------------------------------
// upds_back
// Drains queued packets to the output stage, one result per cycle unless held.
// ----------------------------------------------------------------------------
module upds_back import upds_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  packet_type head,
   input  logic       q_empty,
   output logic       q_pop,
   input  logic       rsp_pop,
   output logic       rsp_empty,
   output logic [7:0] rsp_out_byte,
   output logic [2:0] rsp_section,
   output logic       rsp_byte_valid,
   output logic       rsp_end_of_url,
   output logic [2:0] rsp_status
);

   logic [SlotWidth-1:0] ix_ff, ix_in;
   logic                 valid_ff, valid_in;
   logic [7:0]           byte_ff, byte_in;
   logic [2:0]           sec_ff, sec_in;
   logic                 bvalid_ff, bvalid_in;
   logic                 end_ff, end_in;
   logic [2:0]           stat_ff, stat_in;
   logic                 has_byte, done, load;

   assign has_byte = (ix_ff != head.count);
   assign load     = !q_empty && (!valid_ff || rsp_pop);

   always_comb begin
      done      = 1'b1;
      byte_in   = byte_ff;
      sec_in    = sec_ff;
      bvalid_in = bvalid_ff;
      end_in    = end_ff;
      stat_in   = stat_ff;
      ix_in     = ix_ff;
      valid_in  = valid_ff;
      q_pop     = 1'b0;
      if (has_byte) begin
         done = ((ix_ff + 1'b1) == head.count) && !head.last;
      end
      if (load) begin
         if (has_byte) begin
            byte_in   = head.slot_byte[ix_ff];
            sec_in    = head.slot_sec[ix_ff];
            bvalid_in = 1'b1;
            end_in    = 1'b0;
            stat_in   = StatOk;
         end else begin
            byte_in   = '0;
            sec_in    = SecProto;
            bvalid_in = 1'b0;
            end_in    = 1'b1;
            stat_in   = head.status;
         end
         valid_in = 1'b1;
         if (done) begin
            q_pop = 1'b1;
            ix_in = '0;
         end else begin
            ix_in = ix_ff + 1'b1;
         end
      end else if (rsp_pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ix_ff    <= '0;
         valid_ff <= 1'b0;
      end else begin
         ix_ff    <= ix_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff   <= byte_in;
      sec_ff    <= sec_in;
      bvalid_ff <= bvalid_in;
      end_ff    <= end_in;
      stat_ff   <= stat_in;
   end

   assign rsp_empty      = !valid_ff;
   assign rsp_out_byte   = byte_ff;
   assign rsp_section    = sec_ff;
   assign rsp_byte_valid = bvalid_ff;
   assign rsp_end_of_url = end_ff;
   assign rsp_status     = stat_ff;

endmodule

// ===== src/url_percent_decode_splitter.sv =====
// ----------------------------------------------------------------------------
// url_percent_decode_splitter
// Percent-decodes a URL byte stream and tags each byte with its section.
// ----------------------------------------------------------------------------
// Input channel: push a raw byte on req_in_byte with req_last_byte marking
// the final byte of a URL; a transaction completes when req_push is high and
// req_full is low. One byte is taken every cycle while req_full stays low.
// Result channel: while rsp_empty is low the oldest result is on the rsp_
// ports; rsp_pop takes it. Each input byte yields zero to three byte results
// and the final byte adds one result with rsp_end_of_url high and the status.
// A byte's results pass from the front end through the four-entry packet queue
// and the output register of the back end to the rsp_ ports. One input byte is
// taken per cycle while req_full is low, and one result is sent per cycle while
// the receiver pops; bytes that release held separator characters add results.
// When the receiver stalls, the output register holds its result, the queue
// fills and req_full rises; no transaction is lost or repeated.
// Reset clears the parser state, the queue and the output stage; the block
// takes bytes in the first cycle after reset.
// ----------------------------------------------------------------------------
module url_percent_decode_splitter import upds_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_in_byte,
   input  logic       req_last_byte,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_out_byte,
   output logic [2:0] rsp_section,
   output logic       rsp_byte_valid,
   output logic       rsp_end_of_url,
   output logic [2:0] rsp_status
);

   packet_type pkt, head;
   logic       pkt_push, q_full, q_empty, q_pop;

   assign req_full = q_full;

   upds_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_in_byte   (req_in_byte),
      .req_last_byte (req_last_byte),
      .q_full        (q_full),
      .pkt_push      (pkt_push),
      .pkt           (pkt)
   );

   upds_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (pkt_push),
      .push_data (pkt),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (head),
      .empty     (q_empty)
   );

   upds_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .q_empty        (q_empty),
      .q_pop          (q_pop),
      .rsp_pop        (rsp_pop),
      .rsp_empty      (rsp_empty),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_section    (rsp_section),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_end_of_url (rsp_end_of_url),
      .rsp_status     (rsp_status)
   );

endmodule

// ===== tb/url_split_scoreboard.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// url_split_scoreboard
// Watches both queue channels of the url decoder and splitter. Every byte
// transaction updates a local model of the escape decoder and the section
// parser, which queues the results it should cause; every result transaction
// is compared field by field with the oldest queued result.
// ----------------------------------------------------------------------------
module url_split_scoreboard import upds_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  logic       req_full,
   input  logic [7:0] req_in_byte,
   input  logic       req_last_byte,
   input  logic       rsp_empty,
   input  logic       rsp_pop,
   input  logic [7:0] rsp_out_byte,
   input  logic [2:0] rsp_section,
   input  logic       rsp_byte_valid,
   input  logic       rsp_end_of_url,
   input  logic [2:0] rsp_status,
   output int         error_count,
   output int         pending_count
);

   typedef struct packed {
      logic [7:0] octet;
      logic [2:0] sec;
      logic       vld;
      logic       eou;
      logic [2:0] stat;
   } url_piece_type;

   url_piece_type expected_pieces[$];

   escape_type esc_phase;
   logic [3:0] hi_nib;
   logic [2:0] cur_sec;
   logic [1:0] sep_held;
   logic [2:0] seen;
   logic       has_port;
   logic [2:0] enc_err;

   initial begin
      error_count   = 0;
      pending_count = 0;
   end

   task automatic clear_url();
      esc_phase = ESC_NONE;
      hi_nib    = '0;
      cur_sec   = SecProto;
      sep_held  = '0;
      seen      = '0;
      has_port  = 1'b0;
      enc_err   = StatOk;
   endtask

   // bit 4 set when the character is not a hex digit
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      if (c >= "0" && c <= "9") return {1'b0, c[3:0]};
      if (c >= "a" && c <= "f") return {1'b0, 4'(c - "a" + 8'd10)};
      if (c >= "A" && c <= "F") return {1'b0, 4'(c - "A" + 8'd10)};
      return 5'b1_0000;
   endfunction

   task automatic put_byte(input logic [7:0] b, input logic [2:0] sec);
      expected_pieces.push_back('{octet: b, sec: sec, vld: 1'b1, eou: 1'b0, stat: StatOk});
      if (sec == SecProto) seen[0] = 1'b1;
      else if (sec == SecHost) seen[1] = 1'b1;
      else if (sec == SecPort) seen[2] = 1'b1;
   endtask

   task automatic proto_byte(input logic [7:0] b);
      if (b == CharColon) sep_held = 2'd1;
      else put_byte(b, SecProto);
   endtask

   task automatic split_byte(input logic [7:0] b);
      case (cur_sec)
         SecProto: begin
            if (sep_held == 2'd0) begin
               proto_byte(b);
            end else if (sep_held == 2'd1) begin
               if (b == CharSlash) begin
                  sep_held = 2'd2;
               end else begin
                  sep_held = 2'd0;
                  put_byte(CharColon, SecProto);
                  proto_byte(b);
               end
            end else begin
               sep_held = 2'd0;
               if (b == CharSlash) begin
                  cur_sec = SecHost;
               end else begin
                  put_byte(CharColon, SecProto);
                  put_byte(CharSlash, SecProto);
                  proto_byte(b);
               end
            end
         end
         SecHost: begin
            if (b == CharColon) begin
               cur_sec  = SecPort;
               has_port = 1'b1;
            end else if (b == CharSlash) begin
               cur_sec = SecPath;
            end else begin
               put_byte(b, SecHost);
            end
         end
         SecPort: begin
            if (b == CharSlash) cur_sec = SecPath;
            else put_byte(b, SecPort);
         end
         SecPath: begin
            if (b == CharQuest) cur_sec = SecQuery;
            else put_byte(b, SecPath);
         end
         default: put_byte(b, SecQuery);
      endcase
   endtask

   task automatic take_byte(input logic [7:0] raw, input logic fin);
      logic [4:0] hd;
      logic [2:0] st;
      if (enc_err == StatOk) begin
         if (esc_phase == ESC_NONE) begin
            if (raw == CharPercent) esc_phase = ESC_HIGH;
            else split_byte(raw);
         end else begin
            hd = hex_digit(raw);
            if (hd[4]) begin
               enc_err   = StatBadHex;
               esc_phase = ESC_NONE;
            end else if (esc_phase == ESC_HIGH) begin
               hi_nib    = hd[3:0];
               esc_phase = ESC_LOW;
            end else begin
               esc_phase = ESC_NONE;
               split_byte({hi_nib, hd[3:0]});
            end
         end
      end
      if (fin) begin
         if (enc_err == StatOk && esc_phase != ESC_NONE) enc_err = StatIncomplete;
         if (enc_err != StatOk) begin
            st = enc_err;
         end else if (cur_sec == SecProto) begin
            if (sep_held >= 2'd1) put_byte(CharColon, SecProto);
            if (sep_held >= 2'd2) put_byte(CharSlash, SecProto);
            st = StatNoSep;
         end else if (!seen[0]) begin
            st = StatEmptyProto;
         end else if (has_port && !seen[2]) begin
            st = StatEmptyPort;
         end else if (!seen[1]) begin
            st = StatEmptyHost;
         end else begin
            st = StatOk;
         end
         expected_pieces.push_back('{octet: 8'h00, sec: SecProto, vld: 1'b0, eou: 1'b1,
                                     stat: st});
         clear_url();
      end
   endtask

   always @(posedge clock) begin
      url_piece_type got;
      url_piece_type want;
      if (reset) begin
         clear_url();
         expected_pieces.delete();
      end else begin
         if (req_push && !req_full) take_byte(req_in_byte, req_last_byte);
         if (rsp_pop && !rsp_empty) begin
            got = '{octet: rsp_out_byte, sec: rsp_section, vld: rsp_byte_valid,
                    eou: rsp_end_of_url, stat: rsp_status};
            if (expected_pieces.size() == 0) begin
               error_count++;
               $display("%0t: unexpected transaction, expected none, actual byte %02h sec %0d",
                        $time, got.octet, got.sec,
                        " valid %0d end %0d status %0d", got.vld, got.eou, got.stat);
            end else begin
               want = expected_pieces.pop_front();
               if (got !== want) begin
                  error_count++;
                  $display("%0t: expected byte %02h sec %0d valid %0d end %0d status %0d",
                           $time, want.octet, want.sec, want.vld, want.eou, want.stat);
                  $display("%0t:   actual byte %02h sec %0d valid %0d end %0d status %0d",
                           $time, got.octet, got.sec, got.vld, got.eou, got.stat);
               end
            end
         end
      end
      pending_count = expected_pieces.size();
   end

endmodule

// ===== tb/url_percent_decode_splitter_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// url_percent_decode_splitter_tb
// Feeds directed and random url byte streams into the decoder and splitter
// under changing sender gaps and receiver stalls; the scoreboard checks every
// result transaction and this top gives the verdict.
// ----------------------------------------------------------------------------
module url_percent_decode_splitter_tb;
   import upds_pkg::*;

   localparam int RandomBytes = 210;
   localparam int QuietLimit  = 2000;
   localparam int DrainCycles = 20;

   logic       clock;
   logic       reset;
   logic       req_push;
   logic       req_full;
   logic [7:0] req_in_byte;
   logic       req_last_byte;
   logic       rsp_empty;
   logic       rsp_pop;
   logic [7:0] rsp_out_byte;
   logic [2:0] rsp_section;
   logic       rsp_byte_valid;
   logic       rsp_end_of_url;
   logic [2:0] rsp_status;

   int error_count;
   int pending_count;
   int gap_pct;
   int stall_pct;
   int sent_bytes;
   int quiet_cycles;

   logic [7:0] url_text[$];

   url_percent_decode_splitter dut (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_in_byte    (req_in_byte),
      .req_last_byte  (req_last_byte),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_section    (rsp_section),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_end_of_url (rsp_end_of_url),
      .rsp_status     (rsp_status)
   );

   url_split_scoreboard scoreboard (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_in_byte    (req_in_byte),
      .req_last_byte  (req_last_byte),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_section    (rsp_section),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_end_of_url (rsp_end_of_url),
      .rsp_status     (rsp_status),
      .error_count    (error_count),
      .pending_count  (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      rsp_pop = 1'b0;
      forever begin
         @(posedge clock);
         rsp_pop <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic fin);
      logic held;
      while ($urandom_range(99) < gap_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push      <= 1'b1;
      req_in_byte   <= b;
      req_last_byte <= fin;
      do begin
         @(negedge clock);
         held = req_full;
         @(posedge clock);
      end while (held);
      sent_bytes++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
   endtask

   task automatic send_url();
      for (int i = 0; i < url_text.size(); i++) send_byte(url_text[i], i == url_text.size() - 1);
   endtask

   function automatic logic [7:0] hex_char(input logic [3:0] n, input logic upper);
      if (n < 4'd10) return "0" + 8'(n);
      return (upper ? "A" : "a") + 8'(n) - 8'd10;
   endfunction

   task automatic add_escape(input logic [7:0] v);
      url_text.push_back(CharPercent);
      url_text.push_back(hex_char(v[7:4], 1'($urandom_range(1))));
      url_text.push_back(hex_char(v[3:0], 1'($urandom_range(1))));
   endtask

   function automatic logic [7:0] pick_delim();
      case ($urandom_range(3))
         0: return CharColon;
         1: return CharSlash;
         2: return CharQuest;
         default: return CharPercent;
      endcase
   endfunction

   task automatic add_field(input int len);
      for (int i = 0; i < len; i++) begin
         case ($urandom_range(15))
            0, 1, 2, 3, 4, 5: url_text.push_back("a" + 8'($urandom_range(25)));
            6, 7, 8: url_text.push_back("0" + 8'($urandom_range(9)));
            9, 10, 11: add_escape(8'($urandom_range(255)));
            12: add_escape($urandom_range(4) == 0 ? 8'h00 : pick_delim());
            13: url_text.push_back(pick_delim() == CharPercent ? CharColon : pick_delim());
            14: url_text.push_back(8'($urandom_range(255)));
            default: url_text.push_back("A" + 8'($urandom_range(25)));
         endcase
      end
   endtask

   // mostly well-formed urls with random parts; some noise and broken escapes
   task automatic make_url();
      int kind;
      url_text.delete();
      kind = $urandom_range(15);
      if (kind == 0) begin
         repeat ($urandom_range(1, 8)) url_text.push_back(8'($urandom_range(255)));
      end else begin
         add_field($urandom_range(3));
         if ($urandom_range(9) != 0) begin
            url_text.push_back(CharColon);
            url_text.push_back(CharSlash);
            url_text.push_back(CharSlash);
         end else begin
            url_text.push_back(CharColon);
            if ($urandom_range(1)) url_text.push_back(CharSlash);
            add_field($urandom_range(2));
         end
         add_field($urandom_range(4));
         if ($urandom_range(2) == 0) begin
            url_text.push_back(CharColon);
            add_field($urandom_range(3));
         end
         if ($urandom_range(1)) begin
            url_text.push_back(CharSlash);
            add_field($urandom_range(4));
         end
         if ($urandom_range(2) == 0) begin
            url_text.push_back(CharQuest);
            add_field($urandom_range(3));
         end
         if (kind == 1) begin
            url_text.push_back(CharPercent);
            if ($urandom_range(1)) url_text.push_back(hex_char(4'($urandom_range(15)), 1'b1));
            if ($urandom_range(1)) begin
               url_text.push_back($urandom_range(1) ? "g" : 8'($urandom_range(255)));
               add_field($urandom_range(3));
            end
         end
      end
      if (url_text.size() == 0) url_text.push_back(8'($urandom_range(255)));
   endtask

   initial begin
      reset         = 1'b1;
      req_push      = 1'b0;
      req_in_byte   = '0;
      req_last_byte = 1'b0;
      gap_pct       = 0;
      stall_pct     = 0;
      sent_bytes    = 0;
      quiet_cycles  = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // held separator, empty protocol, 0xff and decoded zero, decoded colon, bad hex, incomplete escape
      send_text("x:/");
      send_text("://");
      send_text("\377://%00:");
      send_text("a%3A//:1");
      send_text("%g");
      send_text("%4");

      sent_bytes = 0;
      while (sent_bytes < RandomBytes) begin
         case (sent_bytes * 4 / RandomBytes)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 52; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 52; end
            default: begin gap_pct = 21; stall_pct = 21; end
         endcase
         make_url();
         send_url();
      end
      req_push <= 1'b0;

      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
